FILE: hdl/lhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhd_pkg
// shared constants, register map and helper functions for the luma downscaler
// ----------------------------------------------------------------------------
package lhd_pkg;

   // register map (word index)
   localparam logic [1:0] REG_FILTER_MODE = 2'd0;
   localparam logic [1:0] REG_OUT_WIDTH   = 2'd1;
   localparam logic [1:0] REG_OUT_HEIGHT  = 2'd2;

   localparam logic        MODE_BOX   = 1'b0;
   localparam logic        MODE_SHARP = 1'b1;

   localparam logic        RST_FILTER_MODE = MODE_SHARP;
   localparam logic [10:0] RST_OUT_WIDTH   = 11'd640;
   localparam logic [10:0] RST_OUT_HEIGHT  = 11'd480;

   // four tap (-1,9,9,-1) with (+8)>>4 rounding on signed 10-bit inputs
   function automatic logic signed [9:0] four_tap(
      input logic signed [9:0] a,
      input logic signed [9:0] b,
      input logic signed [9:0] c,
      input logic signed [9:0] d
   );
      logic signed [15:0] s;
      logic signed [15:0] t;
      s = (16'(b) + 16'(c)) * 16'sd9 - (16'(a) + 16'(d)) + 16'sd8;
      t = s >>> 4;
      return t[9:0];
   endfunction

   // clamp a filtered value to 0..255
   function automatic logic [7:0] clamp8(input logic signed [9:0] v);
      logic [7:0] r;
      if (v < 0) r = 8'd0;
      else if (v > 10'sd255) r = 8'd255;
      else r = v[7:0];
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/lhd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lhd_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: hdl/luma_half_downscaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// luma_half_downscaler
// 2:1 luma downscaler, 2x2 box average or separable 4-tap sharpening filter
// ----------------------------------------------------------------------------
// pipeline: an accepted input word passes the stage 1 registers, then the output register
// throughput: one input word per cycle while the output is not stalled; stage 0
//   reads the line stores, stage 1 filters and loads the output register, both advance together
// reset: synchronous, clears position, pixel window, pipeline valids and
//   loads the register reset values; line stores are not cleared
module luma_half_downscaler #(
   parameter int MAX_OUT_WIDTH  = 1024,
   parameter int MAX_OUT_HEIGHT = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_frame_start,
   input  wire  [7:0]  req_pixel,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_out_pixel,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [3:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int XW = $clog2(MAX_OUT_WIDTH);
   localparam int YW = $clog2(MAX_OUT_HEIGHT) + 1;
   localparam int CW = XW + 1;

   // configuration registers
   logic        filter_mode_ff;
   logic [10:0] out_width_ff, out_height_ff;
   logic [1:0]  reg_idx;
   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= lhd_pkg::RST_FILTER_MODE;
         out_width_ff   <= lhd_pkg::RST_OUT_WIDTH;
         out_height_ff  <= lhd_pkg::RST_OUT_HEIGHT;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            lhd_pkg::REG_FILTER_MODE: filter_mode_ff <= pwdata[0];
            lhd_pkg::REG_OUT_WIDTH:   out_width_ff   <= pwdata[10:0];
            lhd_pkg::REG_OUT_HEIGHT:  out_height_ff  <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         lhd_pkg::REG_FILTER_MODE: prdata = {31'd0, filter_mode_ff};
         lhd_pkg::REG_OUT_WIDTH:   prdata = {21'd0, out_width_ff};
         lhd_pkg::REG_OUT_HEIGHT:  prdata = {21'd0, out_height_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   // effective sizes
   logic [XW:0] w_eff;
   logic [YW-1:0] h_eff;
   always_comb begin
      if (out_width_ff == 11'd0) w_eff = (XW+1)'(1);
      else if (32'(out_width_ff) > MAX_OUT_WIDTH) w_eff = (XW+1)'(MAX_OUT_WIDTH);
      else w_eff = (XW+1)'(out_width_ff);
      if (out_height_ff == 11'd0) h_eff = YW'(1);
      else if (32'(out_height_ff) > MAX_OUT_HEIGHT) h_eff = YW'(MAX_OUT_HEIGHT);
      else h_eff = YW'(out_height_ff);
   end

   // pipeline stall control
   logic s1_valid_ff, s2_valid_ff;
   logic adv;
   assign adv       = !s2_valid_ff || rsp_ready;
   assign req_ready = adv;
   logic take;
   assign take = req_valid && req_ready;

   // position and pixel window
   logic [CW:0]   col_ff;
   logic [YW:0]   row_ff;
   logic [7:0]    win_ff [3];
   logic [CW:0]   sw;
   logic [YW:0]   sh;
   logic [CW:0]   col;
   logic [YW:0]   row;
   assign sw = {w_eff, 1'b0};
   assign sh = {h_eff, 1'b0};
   always_comb begin
      col = col_ff;
      row = row_ff;
      if (req_frame_start || col_ff >= sw || row_ff >= sh) begin
         col = '0;
         row = '0;
      end
   end

   // row slot mod 3 tracking
   logic [1:0] slot_ff, slot;
   always_comb begin
      slot = slot_ff;
      if (row == '0) slot = 2'd0;
   end
   function automatic logic [1:0] sub3(input logic [1:0] s, input logic [1:0] k);
      logic [2:0] t;
      t = {1'b0, s} + 3'd3 - {1'b0, k};
      return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
   endfunction

   // stage 0 decode
   logic have_box, emit_box, have_sh, emit_sh;
   logic [XW-1:0] hx;
   logic [9:0] ha, hb, hc, hd;
   logic [YW-1:0] oy;
   logic [1:0] slot_a, slot_b, slot_c;
   always_comb begin
      have_box = 1'b0; emit_box = 1'b0; have_sh = 1'b0; emit_sh = 1'b0;
      hx = '0; ha = '0; hb = '0; hc = '0; hd = '0; oy = '0;
      slot_a = '0; slot_b = '0; slot_c = '0;
      if (filter_mode_ff == lhd_pkg::MODE_BOX) begin
         if (col[0]) begin
            hx = col[XW:1];
            have_box = 1'b1;
            emit_box = row[0];
            oy = row[YW:1];
         end
      end else begin
         if (!col[0] && col >= (CW+1)'(2)) begin
            hx = XW'((col - (CW+1)'(2)) >> 1);
            ha = {2'b00, (col >= (CW+1)'(3)) ? win_ff[2] : win_ff[1]};
            hb = {2'b00, win_ff[1]};
            hc = {2'b00, win_ff[0]};
            hd = {2'b00, req_pixel};
            have_sh = 1'b1;
         end else if (col == sw - (CW+1)'(1)) begin
            hx = XW'(w_eff - (XW+1)'(1));
            ha = {2'b00, (col >= (CW+1)'(3)) ? win_ff[1] : win_ff[0]};
            hb = {2'b00, win_ff[0]};
            hc = {2'b00, req_pixel};
            hd = {2'b00, req_pixel};
            have_sh = 1'b1;
         end
         if (!row[0] && row >= (YW+1)'(2)) begin
            emit_sh = have_sh;
            oy = YW'((row - (YW+1)'(2)) >> 1);
            slot_a = (row >= (YW+1)'(3)) ? sub3(slot, 2'd3) : 2'd0;
            slot_b = sub3(slot, 2'd2);
            slot_c = sub3(slot, 2'd1);
         end else if (row == sh - (YW+1)'(1)) begin
            emit_sh = have_sh;
            oy = h_eff - YW'(1);
            slot_a = (row >= (YW+1)'(2)) ? sub3(slot, 2'd2) : 2'd0;
            slot_b = sub3(slot, 2'd1);
            slot_c = slot_b;
         end
      end
   end

   // horizontal filter
   logic signed [9:0] hv;
   assign hv = lhd_pkg::four_tap(ha, hb, hc, hd);
   logic [8:0] psum;
   assign psum = {1'b0, win_ff[0]} + {1'b0, req_pixel};

   // stage 0 state update
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; slot_ff <= '0;
         win_ff[0] <= '0; win_ff[1] <= '0; win_ff[2] <= '0;
      end else if (take) begin
         win_ff[2] <= win_ff[1];
         win_ff[1] <= win_ff[0];
         win_ff[0] <= req_pixel;
         if (col + (CW+1)'(1) >= sw) begin
            col_ff <= '0;
            if (row + (YW+1)'(1) >= sh) begin
               row_ff <= '0; slot_ff <= '0;
            end else begin
               row_ff <= row + (YW+1)'(1);
               slot_ff <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
            end
         end else begin
            col_ff <= col + (CW+1)'(1);
            row_ff <= row;
            slot_ff <= slot;
         end
      end
   end

   // line stores: three filtered rows and one pair sum row
   logic [9:0] ra_q, rb_q, rc_q;
   logic [8:0] ps_q;
   logic [1:0] ws0, ws1, ws2;
   logic [9:0] fr_q [3];
   logic       fr_we [3];
   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_rows
         assign fr_we[g] = take && have_sh && slot == 2'(g);
         lhd_ram #(.WIDTH(10), .DEPTH(MAX_OUT_WIDTH)) u_row (
            .clock(clock), .wr_en(fr_we[g]), .wr_addr(hx), .wr_data(hv),
            .rd_en(take), .rd_addr(hx), .rd_data(fr_q[g]));
      end
   endgenerate
   lhd_ram #(.WIDTH(9), .DEPTH(MAX_OUT_WIDTH)) u_pairs (
      .clock(clock), .wr_en(take && have_box && !row[0]), .wr_addr(hx),
      .wr_data(psum), .rd_en(take), .rd_addr(hx), .rd_data(ps_q));

   // stage 1 registers
   logic          s1_box_ff;
   logic [8:0]    s1_psum_ff;
   logic signed [9:0] s1_hv_ff;
   logic [1:0]    s1_sa_ff, s1_sb_ff, s1_sc_ff;
   logic          s1_row_end_ff, s1_frame_end_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= take && (emit_box || emit_sh);
      end
      if (adv) begin
         s1_box_ff <= emit_box;
         s1_psum_ff <= psum;
         s1_hv_ff <= hv;
         s1_sa_ff <= slot_a; s1_sb_ff <= slot_b; s1_sc_ff <= slot_c;
         s1_row_end_ff <= (XW+1)'(hx) == w_eff - (XW+1)'(1);
         s1_frame_end_ff <= ((XW+1)'(hx) == w_eff - (XW+1)'(1))
                            && oy == h_eff - YW'(1);
      end
   end
   assign ws0 = s1_sa_ff; assign ws1 = s1_sb_ff; assign ws2 = s1_sc_ff;
   assign ra_q = fr_q[ws0];
   assign rb_q = fr_q[ws1];
   assign rc_q = (ws2 == ws1) ? s1_hv_ff : fr_q[ws2];

   // stage 1 filter: vertical tap or box mean
   logic [7:0] vout;
   logic [10:0] bsum;
   assign bsum = {2'b00, ps_q} + {2'b00, s1_psum_ff} + 11'd2;
   logic signed [9:0] vd;
   assign vd = s1_hv_ff;
   always_comb begin
      if (s1_box_ff) vout = bsum[9:2];
      else vout = lhd_pkg::clamp8(lhd_pkg::four_tap(ra_q, rb_q, rc_q, vd));
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         rsp_out_pixel <= vout;
         rsp_row_end   <= s1_row_end_ff;
         rsp_frame_end <= s1_frame_end_ff;
      end
   end
   assign rsp_valid = s2_valid_ff;

   // checks
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end) else $error("frame end without row end");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_pixel))
      else $error("output word dropped");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |-> !req_ready) else $error("input taken while stalled");

endmodule
`default_nettype wire
